### hdl/nmcc_pkg.sv
// ----------------------------------------------------------------------------
// nmcc_pkg
// Shared constants, types and state codes for the node mass/charge colormap.
// ----------------------------------------------------------------------------
`default_nettype none

package nmcc_pkg;

  localparam int MAX_NODES = 64;
  localparam int IDX_W     = $clog2(MAX_NODES);
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int BANKS     = 2;
  localparam int ADDR_W    = IDX_W + $clog2(BANKS);
  localparam int RAM_DEPTH = BANKS * MAX_NODES;
  localparam int VAL_W     = 32;
  localparam int CH_W      = 16;
  localparam int RAM_W     = 2 * VAL_W;

  localparam logic [VAL_W-1:0] ONE_Q16    = 32'd65536;
  localparam logic [CH_W-1:0]  FULL_SCALE = 16'hFFFF;

  // one loaded set waiting for emission
  typedef struct packed {
    logic             bank;
    logic [CNT_W-1:0] count;
    logic [VAL_W-1:0] low;
    logic [VAL_W-1:0] range;
    logic [VAL_W-1:0] peak;
  } desc_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [RAM_W-1:0]  data;
  } ram_wr_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            last;
  } color_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_READ,
    B_LOAD,
    B_DIV,
    B_MUL,
    B_EST,
    B_PUSH
  } back_state_e;

endpackage

`default_nettype wire

### hdl/nmcc_ram.sv
// ----------------------------------------------------------------------------
// nmcc_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module nmcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### hdl/nmcc_front.sv
// ----------------------------------------------------------------------------
// nmcc_front
// Load side: stores nodes into the active bank and tracks the set extremes.
// ----------------------------------------------------------------------------
`default_nettype none

module nmcc_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        push_i,
  output logic                             full_o,
  input  wire logic signed [31:0]          node_mass_i,
  input  wire logic signed [31:0]          node_charge_i,
  input  wire logic                        last_node_i,
  input  wire logic                        desc_full_i,
  output logic                             desc_push_o,
  output nmcc_pkg::desc_t                  desc_o,
  output nmcc_pkg::ram_wr_t                ram_wr_o
);
  import nmcc_pkg::*;

  logic [CNT_W-1:0] count_q, count_d;
  logic signed [VAL_W-1:0] low_q, low_d, high_q, high_d;
  logic [VAL_W-1:0] peak_q, peak_d;
  logic bank_q, bank_d;

  logic acc, room;
  logic [VAL_W-1:0] mag_in;
  logic signed [VAL_W-1:0] low_n, high_n;
  logic [VAL_W-1:0] peak_n;
  logic [CNT_W-1:0] count_n;
  logic [VAL_W:0] diff;
  logic [VAL_W-1:0] range_w;

  assign full_o = desc_full_i;
  assign acc    = push_i && !desc_full_i;
  assign room   = count_q < CNT_W'(MAX_NODES);
  assign mag_in = node_charge_i[VAL_W-1] ? (~node_charge_i + 32'd1) : node_charge_i;

  always_comb begin
    low_n   = (room && (node_mass_i < low_q)) ? node_mass_i : low_q;
    high_n  = (room && (node_mass_i > high_q)) ? node_mass_i : high_q;
    peak_n  = (room && (mag_in > peak_q)) ? mag_in : peak_q;
    count_n = room ? count_q + CNT_W'(1) : count_q;
    diff    = {high_n[VAL_W-1], high_n} - {low_n[VAL_W-1], low_n};
    range_w = (diff[VAL_W-1:0] == '0) ? ONE_Q16 : diff[VAL_W-1:0];

    desc_push_o  = acc && last_node_i && (count_n != '0);
    desc_o.bank  = bank_q;
    desc_o.count = count_n;
    desc_o.low   = low_n;
    desc_o.range = range_w;
    desc_o.peak  = (peak_n == '0) ? ONE_Q16 : peak_n;

    ram_wr_o.en   = acc && room;
    ram_wr_o.addr = {bank_q, count_q[IDX_W-1:0]};
    ram_wr_o.data = {node_mass_i, node_charge_i};

    count_d = count_q;
    low_d   = low_q;
    high_d  = high_q;
    peak_d  = peak_q;
    bank_d  = bank_q;
    if (acc) begin
      if (last_node_i) begin
        count_d = '0;
        low_d   = 32'sh7FFF_FFFF;
        high_d  = 32'sh8000_0000;
        peak_d  = '0;
        if (desc_push_o) begin
          bank_d = ~bank_q;
        end
      end else begin
        count_d = count_n;
        low_d   = low_n;
        high_d  = high_n;
        peak_d  = peak_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      low_q   <= 32'sh7FFF_FFFF;
      high_q  <= 32'sh8000_0000;
      peak_q  <= '0;
      bank_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      low_q   <= low_d;
      high_q  <= high_d;
      peak_q  <= peak_d;
      bank_q  <= bank_d;
    end
  end

endmodule

`default_nettype wire

### hdl/nmcc_desc_q.sv
// ----------------------------------------------------------------------------
// nmcc_desc_q
// Two-entry queue of loaded sets between the load side and the emit side.
// ----------------------------------------------------------------------------
`default_nettype none

module nmcc_desc_q (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire nmcc_pkg::desc_t data_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 valid_o,
  output nmcc_pkg::desc_t      data_o
);
  import nmcc_pkg::*;

  desc_t      mem_q [BANKS];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

`default_nettype wire

### hdl/nmcc_div.sv
// ----------------------------------------------------------------------------
// nmcc_div
// Radix-2 divider for floor(num * 65535 / den), num <= den.
// ----------------------------------------------------------------------------
`default_nettype none

module nmcc_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] num_i,
  input  wire logic [31:0] den_i,
  output logic             busy_o,
  output logic [15:0]      quo_o
);
  import nmcc_pkg::*;

  logic [VAL_W-1:0] rem_q, den_q;
  logic [CH_W-1:0]  low_q, quo_q;
  logic [4:0]       cnt_q;
  logic             busy_q;
  logic [47:0]      scaled;
  logic [VAL_W:0]   sh;
  logic [VAL_W:0]   sub;

  // num * 65535 as a shift and subtract
  assign scaled = {num_i, 16'b0} - {16'b0, num_i};
  assign sh     = {rem_q, low_q[CH_W-1]};
  assign sub    = sh - {1'b0, den_q};
  assign busy_o = busy_q;
  assign quo_o  = quo_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= scaled[47:16];
      low_q <= scaled[15:0];
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= sub[VAL_W] ? sh[VAL_W-1:0] : sub[VAL_W-1:0];
      quo_q <= {quo_q[CH_W-2:0], ~sub[VAL_W]};
      low_q <= {low_q[CH_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 5'd16;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 5'd1;
      if (cnt_q == 5'd1) busy_q <= 1'b0;
    end
  end

endmodule

`default_nettype wire

### hdl/nmcc_back.sv
// ----------------------------------------------------------------------------
// nmcc_back
// Emit side: reads each stored node, normalizes it and queues its color.
// ----------------------------------------------------------------------------
`default_nettype none

module nmcc_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        desc_valid_i,
  input  wire nmcc_pkg::desc_t             desc_i,
  output logic                             desc_pop_o,
  output logic                             ram_re_o,
  output logic [nmcc_pkg::ADDR_W-1:0]      ram_raddr_o,
  input  wire logic [nmcc_pkg::RAM_W-1:0]  ram_rdata_i,
  input  wire logic                        pop_i,
  output logic                             empty_o,
  output nmcc_pkg::color_t                 color_o
);
  import nmcc_pkg::*;

  back_state_e state_q, state_d;
  logic [IDX_W-1:0] idx_q;
  logic neg_q, pos_q;
  logic [VAL_W-1:0] pr_q, pg_q, pb_q;
  logic [CH_W-1:0]  er_q, eg_q, eb_q;

  logic start;
  logic signed [VAL_W-1:0] mass, charge;
  logic [VAL_W:0]   d_full;
  logic [VAL_W-1:0] mag_raw, mag;
  logic             busy_b, busy_s, busy_r;
  logic [CH_W-1:0]  q_bright, q_s, q_q;
  logic [CH_W-1:0]  w_r, w_b;
  logic             is_last;
  logic             oq_full, oq_push;
  color_t           oq_mem_q [2];
  logic             oq_wr_q, oq_rd_q;
  logic [1:0]       oq_cnt_q;
  color_t           res;

  // quotient estimate for p / 65535 is at most one short
  function automatic logic [CH_W-1:0] est65535(input logic [VAL_W-1:0] p);
    logic [VAL_W-1:0] s;
    s = p + {16'b0, p[VAL_W-1:16]};
    return s[VAL_W-1:16];
  endfunction

  function automatic logic [CH_W-1:0] fix65535(input logic [VAL_W-1:0] p,
                                               input logic [CH_W-1:0] e);
    logic [VAL_W:0] r;
    r = {1'b0, p} - {1'b0, e, 16'b0} + {17'b0, e};
    return (r >= {17'b0, FULL_SCALE}) ? e + 16'd1 : e;
  endfunction

  assign mass    = ram_rdata_i[RAM_W-1:VAL_W];
  assign charge  = ram_rdata_i[VAL_W-1:0];
  assign d_full  = {mass[VAL_W-1], mass} - {desc_i.low[VAL_W-1], desc_i.low};
  assign mag_raw = charge[VAL_W-1] ? (~charge + 32'd1) : charge;
  assign mag     = (mag_raw > desc_i.peak) ? desc_i.peak : mag_raw;
  assign is_last = ({1'b0, idx_q} + CNT_W'(1)) == desc_i.count;

  nmcc_div u_div_b (
    .clk_i, .rst_ni, .start_i(start), .num_i(d_full[VAL_W-1:0]),
    .den_i(desc_i.range), .busy_o(busy_b), .quo_o(q_bright)
  );
  nmcc_div u_div_s (
    .clk_i, .rst_ni, .start_i(start), .num_i(mag),
    .den_i(desc_i.peak), .busy_o(busy_s), .quo_o(q_s)
  );
  nmcc_div u_div_q (
    .clk_i, .rst_ni, .start_i(start), .num_i(desc_i.peak - mag),
    .den_i(desc_i.peak), .busy_o(busy_r), .quo_o(q_q)
  );

  assign w_r = neg_q ? q_s : q_q;
  assign w_b = pos_q ? q_s : q_q;

  always_comb begin
    res.red   = fix65535(pr_q, er_q);
    res.green = fix65535(pg_q, eg_q);
    res.blue  = fix65535(pb_q, eb_q);
    res.last  = is_last;
  end

  always_comb begin
    state_d     = state_q;
    start       = 1'b0;
    ram_re_o    = 1'b0;
    ram_raddr_o = {desc_i.bank, idx_q};
    oq_push     = 1'b0;
    desc_pop_o  = 1'b0;
    unique case (state_q)
      B_IDLE: if (desc_valid_i) state_d = B_READ;
      B_READ: begin
        ram_re_o = 1'b1;
        state_d  = B_LOAD;
      end
      B_LOAD: begin
        start   = 1'b1;
        state_d = B_DIV;
      end
      B_DIV:  if (!busy_b && !busy_s && !busy_r) state_d = B_MUL;
      B_MUL:  state_d = B_EST;
      B_EST:  state_d = B_PUSH;
      B_PUSH: begin
        if (!oq_full) begin
          oq_push = 1'b1;
          if (is_last) begin
            desc_pop_o = 1'b1;
            state_d    = B_IDLE;
          end else begin
            state_d = B_READ;
          end
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == B_IDLE) idx_q <= '0;
      else if (oq_push)      idx_q <= idx_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == B_LOAD) begin
      neg_q <= charge[VAL_W-1];
      pos_q <= !charge[VAL_W-1] && (charge != '0);
    end
    if (state_q == B_MUL) begin
      pr_q <= VAL_W'(q_bright) * VAL_W'(w_r);
      pg_q <= VAL_W'(q_bright) * VAL_W'(q_q);
      pb_q <= VAL_W'(q_bright) * VAL_W'(w_b);
    end
    if (state_q == B_EST) begin
      er_q <= est65535(pr_q);
      eg_q <= est65535(pg_q);
      eb_q <= est65535(pb_q);
    end
  end

  // result queue parts the emit pipeline from the receiver
  assign oq_full = oq_cnt_q == 2'd2;
  assign empty_o = oq_cnt_q == 2'd0;
  assign color_o = oq_mem_q[oq_rd_q];

  always_ff @(posedge clk_i) begin
    if (oq_push) oq_mem_q[oq_wr_q] <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= 1'b0;
      oq_rd_q  <= 1'b0;
      oq_cnt_q <= 2'd0;
    end else begin
      if (oq_push)            oq_wr_q <= ~oq_wr_q;
      if (pop_i && !empty_o)  oq_rd_q <= ~oq_rd_q;
      oq_cnt_q <= oq_cnt_q + {1'b0, oq_push} - {1'b0, pop_i && !empty_o};
    end
  end

endmodule

`default_nettype wire

### hdl/node_mass_charge_colormap.sv
// ----------------------------------------------------------------------------
// node_mass_charge_colormap
// Mass/charge to RGB colormap over sets of up to 64 nodes.
// ----------------------------------------------------------------------------
// Input queue: push_i/full_o carry one node (mass, charge, last mark) per
// transaction; full_o is low while a bank is free.
// Nodes go into one of two RAM banks, so a new set loads while the previous
// one is still being emitted; full_o rises only when both banks hold sets.
// Nodes past 64 in a set are dropped, but their last mark still closes it.
// Result queue: empty_o/pop_i; one color per stored node, in load order, with
// last_color_o on the final one. The emit side finishes each node before it
// reads the next: per node one RAM read, three parallel radix-2 dividers, a
// multiply and a reciprocal fix.
// A two-entry result queue absorbs a stalled receiver; once it fills, the
// emit side waits and the load side keeps accepting until both banks fill.
// Reset clears all control state and trackers; RAM contents need no clear.
// ----------------------------------------------------------------------------
`default_nettype none

module node_mass_charge_colormap (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  output logic             full_o,
  input  wire logic [31:0] node_mass_i,
  input  wire logic [31:0] node_charge_i,
  input  wire logic        last_node_i,
  output logic             empty_o,
  input  wire logic        pop_i,
  output logic [15:0]      red_o,
  output logic [15:0]      green_o,
  output logic [15:0]      blue_o,
  output logic             last_color_o
);
  import nmcc_pkg::*;

  desc_t             desc_in, desc_head;
  logic              desc_push, desc_pop, desc_full, desc_valid;
  ram_wr_t           ram_wr;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [RAM_W-1:0]  ram_rdata;
  color_t            color;

  nmcc_front u_front (
    .clk_i, .rst_ni, .push_i, .full_o,
    .node_mass_i(node_mass_i), .node_charge_i(node_charge_i),
    .last_node_i, .desc_full_i(desc_full), .desc_push_o(desc_push),
    .desc_o(desc_in), .ram_wr_o(ram_wr)
  );

  nmcc_desc_q u_desc_q (
    .clk_i, .rst_ni, .push_i(desc_push), .data_i(desc_in), .full_o(desc_full),
    .pop_i(desc_pop), .valid_o(desc_valid), .data_o(desc_head)
  );

  nmcc_ram #(.WIDTH(RAM_W), .DEPTH(RAM_DEPTH)) u_ram (
    .clk_i, .we_i(ram_wr.en), .waddr_i(ram_wr.addr), .wdata_i(ram_wr.data),
    .re_i(ram_re), .raddr_i(ram_raddr), .rdata_o(ram_rdata)
  );

  nmcc_back u_back (
    .clk_i, .rst_ni, .desc_valid_i(desc_valid), .desc_i(desc_head),
    .desc_pop_o(desc_pop), .ram_re_o(ram_re), .ram_raddr_o(ram_raddr),
    .ram_rdata_i(ram_rdata), .pop_i, .empty_o, .color_o(color)
  );

  assign red_o        = color.red;
  assign green_o      = color.green;
  assign blue_o       = color.blue;
  assign last_color_o = color.last;

endmodule

`default_nettype wire

### hdl/nmcc_checker.sv
// ----------------------------------------------------------------------------
// nmcc_checker
// Port-level checks of the colormap result queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module nmcc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        empty_o,
  input wire logic        pop_i,
  input wire logic [15:0] red_o,
  input wire logic [15:0] green_o,
  input wire logic [15:0] blue_o,
  input wire logic        last_color_o
);

  // a waiting result is not dropped while the receiver stalls
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=> !empty_o)
    else $error("result vanished while stalled");

  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=> ($stable(red_o) && $stable(green_o) &&
                              $stable(blue_o) && $stable(last_color_o)))
    else $error("stalled result changed");

  // at most one of red and blue is steered, the other follows green
  a_steer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> (red_o == green_o || blue_o == green_o))
    else $error("both red and blue differ from green");

  // the result queue leaves reset empty
  a_reset: assert property (@(posedge clk_i) $rose(rst_ni) |-> empty_o)
    else $error("result queue not empty after reset");

endmodule

bind node_mass_charge_colormap nmcc_checker u_nmcc_checker (.*);

`default_nettype wire
